// File: src/lom_pkg.sv
// Shared types and codes for the limit order matcher.
package lom_pkg;

  typedef enum logic [1:0] {
    KIND_FILL   = 2'd0,
    KIND_RESTED = 2'd1,
    KIND_REJECT = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MRD,
    ST_MEV,
    ST_INS,
    ST_SRD,
    ST_SEV,
    ST_PUT
  } state_e;

  localparam logic SIDE_BID = 1'b0;
  localparam logic SIDE_ASK = 1'b1;

endpackage

// File: src/limit_order_matcher.sv
// Limit order matcher top level: two circular price-time books in one RAM.
// Steps: each fill and the final best-price check are a RAM read, then a compare and update;
// an empty opposite side skips the compare. A reject is then issued directly; a rest reads
// and compares own-side entries from the tail until a slot opens, then writes the order.
// A result is registered and shows in the cycle after its step; busy drops as the last shows.
// Reset clears head and count registers at once; RAM needs no clearing; receiver cannot stall.
module limit_order_matcher
  import lom_pkg::*;
#(
  parameter int BOOK_DEPTH  = 32,
  parameter int PRICE_BITS  = 16,
  parameter int QTY_BITS    = 16,
  parameter int TRADER_BITS = 8
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start,
  output logic                   busy,
  input  logic                   is_buy_i,
  input  logic [PRICE_BITS-1:0]  limit_price_i,
  input  logic [QTY_BITS-1:0]    order_qty_i,
  input  logic [TRADER_BITS-1:0] trader_i,
  output logic                   result_valid_o,
  output logic [1:0]             kind_o,
  output logic [PRICE_BITS-1:0]  fill_price_o,
  output logic [QTY_BITS-1:0]    fill_qty_o,
  output logic [TRADER_BITS-1:0] resting_trader_o,
  output logic [TRADER_BITS-1:0] aggressor_trader_o,
  output logic [QTY_BITS-1:0]    remaining_qty_o,
  output logic                   last_o
);

  localparam int IW = (BOOK_DEPTH > 1) ? $clog2(BOOK_DEPTH) : 1;
  localparam int CW = $clog2(BOOK_DEPTH + 1);
  localparam int EW = PRICE_BITS + QTY_BITS + TRADER_BITS;
  localparam int RAM_DEPTH = 2 * (2 ** IW);
  localparam logic [CW-1:0] FULL = CW'(BOOK_DEPTH);
  localparam logic [IW:0] DEPTH_W = (IW + 1)'(BOOK_DEPTH);

  state_e state_q, state_d;

  logic [IW-1:0] head_q [2];
  logic [CW-1:0] cnt_q  [2];

  logic                   buy_q;
  logic [PRICE_BITS-1:0]  limit_q;
  logic [QTY_BITS-1:0]    rem_q;
  logic [TRADER_BITS-1:0] who_q;
  logic [IW-1:0]          idx_q;

  logic          we;
  logic [IW:0]   waddr, raddr;
  logic [EW-1:0] wdata, rdata;

  lom_ram #(.WIDTH(EW), .DEPTH(RAM_DEPTH)) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  function automatic logic [IW:0] phys(logic side, logic [IW-1:0] head, logic [IW-1:0] pos);
    logic [IW:0] s;
    s = {1'b0, head} + {1'b0, pos};
    if (s >= DEPTH_W) begin
      s = s - DEPTH_W;
    end
    return {side, s[IW-1:0]};
  endfunction

  logic opp, own;
  assign opp = buy_q ? SIDE_ASK : SIDE_BID;
  assign own = buy_q ? SIDE_BID : SIDE_ASK;

  logic [PRICE_BITS-1:0]  rp;
  logic [QTY_BITS-1:0]    rq;
  logic [TRADER_BITS-1:0] ro;
  assign {rp, rq, ro} = rdata;

  logic [QTY_BITS-1:0] fill;
  logic [QTY_BITS-1:0] rem_next;
  logic                no_cross, worse;
  logic [IW-1:0]       idx_m1;
  assign fill     = (rq < rem_q) ? rq : rem_q;
  assign rem_next = rem_q - fill;
  assign no_cross = buy_q ? (rp > limit_q) : (rp < limit_q);
  assign worse    = buy_q ? (rp < limit_q) : (rp > limit_q);
  assign idx_m1   = idx_q - IW'(1);

  assign busy = (state_q != ST_IDLE);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (start && order_qty_i != '0) state_d = ST_MRD;
      ST_MRD:  state_d = (cnt_q[opp] == '0) ? ST_INS : ST_MEV;
      ST_MEV: begin
        if (no_cross) state_d = ST_INS;
        else if (rem_next == '0) state_d = ST_IDLE;
        else state_d = ST_MRD;
      end
      ST_INS: begin
        if (cnt_q[own] == FULL) state_d = ST_IDLE;
        else if (cnt_q[own] == '0) state_d = ST_PUT;
        else state_d = ST_SRD;
      end
      ST_SRD:  state_d = ST_SEV;
      ST_SEV:  state_d = (worse && idx_m1 != '0) ? ST_SRD : ST_PUT;
      ST_PUT:  state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // memory control and result selection
  logic                  emit;
  kind_e                 e_kind;
  logic                  e_last;
  logic [PRICE_BITS-1:0] e_price;
  logic [QTY_BITS-1:0]   e_qty, e_rem;
  logic [TRADER_BITS-1:0] e_rest;

  always_comb begin
    we      = 1'b0;
    waddr   = phys(own, head_q[own], idx_q);
    wdata   = {limit_q, rem_q, who_q};
    raddr   = phys(opp, head_q[opp], '0);
    emit    = 1'b0;
    e_kind  = KIND_FILL;
    e_last  = 1'b0;
    e_price = '0;
    e_qty   = '0;
    e_rest  = '0;
    e_rem   = rem_q;
    unique case (state_q)
      ST_MEV: begin
        if (!no_cross) begin
          emit    = 1'b1;
          e_price = rp;
          e_qty   = fill;
          e_rest  = ro;
          e_rem   = rem_next;
          e_last  = (rem_next == '0);
          if (rq != fill) begin
            we    = 1'b1;
            waddr = phys(opp, head_q[opp], '0);
            wdata = {rp, rq - fill, ro};
          end
        end
      end
      ST_INS: begin
        if (cnt_q[own] == FULL) begin
          emit   = 1'b1;
          e_kind = KIND_REJECT;
          e_last = 1'b1;
        end
      end
      ST_SRD: raddr = phys(own, head_q[own], idx_m1);
      ST_SEV: begin
        // move a worse-priced entry back one slot
        if (worse) begin
          we    = 1'b1;
          wdata = rdata;
        end
      end
      ST_PUT: begin
        we     = 1'b1;
        emit   = 1'b1;
        e_kind = KIND_RESTED;
        e_last = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      head_q[0]      <= '0;
      head_q[1]      <= '0;
      cnt_q[0]       <= '0;
      cnt_q[1]       <= '0;
      result_valid_o <= 1'b0;
    end else begin
      state_q        <= state_d;
      result_valid_o <= emit;
      if (state_q == ST_MEV && !no_cross && rq == fill) begin
        head_q[opp] <= (head_q[opp] == IW'(BOOK_DEPTH - 1)) ? '0 : head_q[opp] + IW'(1);
        cnt_q[opp]  <= cnt_q[opp] - CW'(1);
      end
      if (state_q == ST_PUT) begin
        cnt_q[own] <= cnt_q[own] + CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && start) begin
      buy_q   <= is_buy_i;
      limit_q <= limit_price_i;
      rem_q   <= order_qty_i;
      who_q   <= trader_i;
    end
    if (state_q == ST_MEV && !no_cross) begin
      rem_q <= rem_next;
    end
    if (state_q == ST_INS) begin
      idx_q <= cnt_q[own][IW-1:0];
    end
    if (state_q == ST_SEV && worse) begin
      idx_q <= idx_m1;
    end
    if (emit) begin
      kind_o             <= e_kind;
      fill_price_o       <= e_price;
      fill_qty_o         <= e_qty;
      resting_trader_o   <= e_rest;
      aggressor_trader_o <= who_q;
      remaining_qty_o    <= e_rem;
      last_o             <= e_last;
    end
  end

endmodule

// File: src/lom_ram.sv
// Generic single-write, single-read RAM with registered read data.
module lom_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

// File: src/lom_checker.sv
// Port-level checks for the limit order matcher, bound to the top level.
module lom_checker
  import lom_pkg::*;
#(
  parameter int PRICE_BITS  = 16,
  parameter int QTY_BITS    = 16,
  parameter int TRADER_BITS = 8
) (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   start,
  input logic                   busy,
  input logic [QTY_BITS-1:0]    order_qty_i,
  input logic                   result_valid_o,
  input logic [1:0]             kind_o,
  input logic [QTY_BITS-1:0]    fill_qty_o,
  input logic [QTY_BITS-1:0]    remaining_qty_o,
  input logic                   last_o
);

  a_kind_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (kind_o == KIND_FILL || kind_o == KIND_RESTED ||
                        kind_o == KIND_REJECT))
    else $error("illegal result kind");

  a_fill_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && kind_o == KIND_FILL |-> fill_qty_o != '0)
    else $error("fill with zero quantity");

  a_close_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && kind_o != KIND_FILL |-> last_o && fill_qty_o == '0 &&
                                              remaining_qty_o != '0)
    else $error("closing result malformed");

  a_fill_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && kind_o == KIND_FILL |-> last_o == (remaining_qty_o == '0))
    else $error("fill last flag disagrees with remainder");

  a_busy_after_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && order_qty_i != '0 |=> busy)
    else $error("request accepted but not busy");

endmodule

bind limit_order_matcher lom_checker #(
  .PRICE_BITS  (PRICE_BITS),
  .QTY_BITS    (QTY_BITS),
  .TRADER_BITS (TRADER_BITS)
) u_lom_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .start           (start),
  .busy            (busy),
  .order_qty_i     (order_qty_i),
  .result_valid_o  (result_valid_o),
  .kind_o          (kind_o),
  .fill_qty_o      (fill_qty_o),
  .remaining_qty_o (remaining_qty_o),
  .last_o          (last_o)
);
